>>> src/bis_pkg.sv
`default_nettype none

package bis_pkg;

  localparam int unsigned CapacityDef  = 1024;
  localparam int unsigned WordBitsDef  = 32;
  localparam int unsigned WordCountDef = 32;

  localparam int unsigned LowBoundW = 32;
  localparam int unsigned SpanW     = 10;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CountW    = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [SpanW-1:0] SpanReset = '1;

  typedef enum logic [ModeW-1:0] {
    ModeFind       = 3'd0,
    ModeAdd        = 3'd1,
    ModeRemove     = 3'd2,
    ModeClear      = 3'd3,
    ModeComplement = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLowBound  = 1'b0,
    CfgRangeSpan = 1'b1
  } cfg_idx_e;

  // control from the item stage to the map
  typedef struct packed {
    logic             go;
    logic             wipe;
    logic             in_range;
    logic [ModeW-1:0] mode;
  } map_req_t;

endpackage

`default_nettype wire

>>> src/bitmap_integer_set.sv
`default_nettype none

// channel  | valid         | stall         | payload
// ---------+---------------+---------------+--------------------------------------
// in       | in_valid_i    | in_stall_o    | mode_i, value_i
// out      | out_valid_o   | out_stall_i   | success_o, out_of_range_o, member_count_o
// config   | cfg_we_i      | (none)        | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the result is not stalled; a beat is held
// in the input register, the map lookup/update runs between that register
// and the result register, which drives the outputs.
// reset empties the map, clears the count and sets the bounds to 0..1023.
// a stalled result holds the input register; new beats are stalled only when
// both registers are full and the result is stalled. any config write empties the set.

module bitmap_integer_set #(
  parameter int unsigned CAPACITY   = bis_pkg::CapacityDef,
  parameter int unsigned WORD_BITS  = bis_pkg::WordBitsDef,
  parameter int unsigned WORD_COUNT = bis_pkg::WordCountDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bis_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bis_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [bis_pkg::ModeW-1:0]       mode_i,
  input  wire logic signed [bis_pkg::ValueW-1:0] value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 success_o,
  output logic                                 out_of_range_o,
  output logic [bis_pkg::CountW-1:0]           member_count_o
);

  localparam int unsigned MapBits  = WORD_BITS * WORD_COUNT;
  localparam int unsigned CapBits  = (CAPACITY < MapBits) ? CAPACITY : MapBits;
  localparam int unsigned TopLimit = CapBits - 1;
  localparam int unsigned IdxW     = $clog2(MapBits);

  logic signed [bis_pkg::LowBoundW-1:0] low_bound_q;
  logic [bis_pkg::SpanW-1:0]            range_span_q;

  logic                                 in_valid_q;
  logic [bis_pkg::ModeW-1:0]            mode_q;
  logic signed [bis_pkg::ValueW-1:0]    value_q;

  logic                                 out_valid_q, success_q, oor_q;
  logic [bis_pkg::CountW-1:0]           count_q;

  logic                                 accept, process;
  logic [bis_pkg::SpanW-1:0]            top;
  logic [32:0]                          offset;
  logic                                 in_range, map_mode;
  bis_pkg::map_req_t                    req;
  logic                                 map_success;
  logic [bis_pkg::CountW-1:0]           map_count;

  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign process    = in_valid_q & ~(out_valid_q & out_stall_i);

  always_comb begin
    if (32'(range_span_q) > TopLimit) top = bis_pkg::SpanW'(TopLimit);
    else                              top = range_span_q;
  end

  // 33-bit difference never overflows
  assign offset   = {value_q[bis_pkg::ValueW-1], value_q}
                  - {low_bound_q[bis_pkg::LowBoundW-1], low_bound_q};
  assign in_range = ~offset[32] & (offset <= 33'(top));
  assign map_mode = (mode_q == bis_pkg::ModeFind) || (mode_q == bis_pkg::ModeAdd)
                 || (mode_q == bis_pkg::ModeRemove);

  assign req.go       = process;
  assign req.wipe     = cfg_we_i;
  assign req.in_range = in_range;
  assign req.mode     = mode_q;

  bis_map #(
    .MapBits (MapBits),
    .CapBits (CapBits)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .off_i     (offset[IdxW-1:0]),
    .top_i     (top),
    .success_o (map_success),
    .count_o   (map_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bound_q  <= '0;
      range_span_q <= bis_pkg::SpanReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bis_pkg::CfgLowBound:  low_bound_q  <= cfg_data_i[bis_pkg::LowBoundW-1:0];
        bis_pkg::CfgRangeSpan: range_span_q <= cfg_data_i[bis_pkg::SpanW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      success_q <= map_success;
      oor_q     <= map_mode & ~in_range;
      count_q   <= map_count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign success_o      = success_q;
  assign out_of_range_o = oor_q;
  assign member_count_o = count_q;

endmodule

`default_nettype wire

>>> src/bis_map.sv
`default_nettype none

module bis_map #(
  parameter int unsigned MapBits = 1024,
  parameter int unsigned CapBits = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bis_pkg::map_req_t            req_i,
  input  wire logic [$clog2(MapBits)-1:0]   off_i,
  input  wire logic [bis_pkg::SpanW-1:0]    top_i,
  output logic                              success_o,
  output logic [bis_pkg::CountW-1:0]        count_o
);

  localparam int unsigned TallyW = $clog2(CapBits + 1);

  logic [MapBits-1:0] map_q, map_d, flip_mask;
  logic [TallyW-1:0]  tally_q, tally_d, span_count;
  logic               present;
  logic [31:0]        tally_wide;

  assign present    = map_q[off_i];
  assign span_count = TallyW'(top_i) + TallyW'(1);

  // bits at or below the top offset take part in a complement
  always_comb begin
    for (int i = 0; i < MapBits; i++) begin
      flip_mask[i] = (32'(i) <= {{(32-bis_pkg::SpanW){1'b0}}, top_i});
    end
  end

  always_comb begin
    map_d     = map_q;
    tally_d   = tally_q;
    success_o = 1'b0;
    if (req_i.wipe) begin
      map_d   = '0;
      tally_d = '0;
    end else if (req_i.go) begin
      case (req_i.mode)
        bis_pkg::ModeFind: begin
          success_o = req_i.in_range & present;
        end
        bis_pkg::ModeAdd: begin
          if (req_i.in_range && !present) begin
            map_d[off_i] = 1'b1;
            tally_d      = tally_q + TallyW'(1);
            success_o    = 1'b1;
          end
        end
        bis_pkg::ModeRemove: begin
          if (req_i.in_range && present) begin
            map_d[off_i] = 1'b0;
            if (tally_q != '0) tally_d = tally_q - TallyW'(1);
            success_o    = 1'b1;
          end
        end
        bis_pkg::ModeClear: begin
          map_d   = '0;
          tally_d = '0;
        end
        bis_pkg::ModeComplement: begin
          map_d   = map_q ^ flip_mask;
          tally_d = (tally_q <= span_count) ? (span_count - tally_q) : '0;
        end
        default: ;
      endcase
    end
  end

  assign tally_wide = 32'(tally_d);
  assign count_o    = tally_wide[bis_pkg::CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      tally_q <= '0;
    end else begin
      map_q   <= map_d;
      tally_q <= tally_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/bitmap_set_checker.sv
module bitmap_set_checker
  import bis_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [CfgDataW-1:0]      cfg_data_i,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_stall_i,
  input  wire logic [ModeW-1:0]         mode_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_stall_i,
  input  wire logic                     success_i,
  input  wire logic                     out_of_range_i,
  input  wire logic [CountW-1:0]        member_count_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ModeW-1:0]         mode;
    logic signed [ValueW-1:0] value;
    logic                     success;
    logic                     out_of_range;
    logic [CountW-1:0]        member_count;
  } answer_t;

  // own copy of the set and its bounds, reset state as after power-up
  logic [CapacityDef-1:0]         held_bits  = '0;
  logic signed [LowBoundW-1:0]    base_value = '0;
  logic [SpanW-1:0]               span_reg   = SpanReset;
  int unsigned                    tally      = 0;
  answer_t                        awaited_answers[$];
  int                             fails      = 0;
  int                             checked    = 0;

  function automatic answer_t predict_set_op(logic [ModeW-1:0] m, logic signed [ValueW-1:0] v);
    answer_t     a;
    longint      off;
    int unsigned top;
    a.mode         = m;
    a.value        = v;
    a.success      = 1'b0;
    a.out_of_range = 1'b0;
    // offset taken in 64 bits so it cannot wrap
    off = longint'(v) - longint'(base_value);
    top = (span_reg < CapacityDef) ? span_reg : CapacityDef - 1;
    case (m)
      ModeFind, ModeAdd, ModeRemove: begin
        if (off < 0 || off > longint'(top)) begin
          a.out_of_range = 1'b1;
        end else if (m == ModeFind) begin
          a.success = held_bits[off];
        end else if (m == ModeAdd) begin
          if (!held_bits[off]) begin
            held_bits[off] = 1'b1;
            tally++;
            a.success = 1'b1;
          end
        end else if (held_bits[off]) begin
          held_bits[off] = 1'b0;
          tally--;
          a.success = 1'b1;
        end
      end
      ModeClear: begin
        held_bits = '0;
        tally     = 0;
      end
      ModeComplement: begin
        for (int i = 0; i <= top; i++) held_bits[i] = ~held_bits[i];
        tally = top + 1 - tally;
      end
      default: ;
    endcase
    a.member_count = tally[CountW-1:0];
    return a;
  endfunction

  function automatic int field_off(string name, int expected, int actual);
    if (expected == actual) return 0;
    $display("%0t %s: expected %0d, actual %0d", $time, name, expected, actual);
    return 1;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    int      miss;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (awaited_answers.size() == 0) begin
          fails++;
          $display("%0t result beat with nothing awaited: expected none, actual %0b/%0b/%0d",
                   $time, success_i, out_of_range_i, member_count_i);
        end else begin
          want = awaited_answers.pop_front();
          miss = field_off("success", want.success, success_i)
               + field_off("out_of_range", want.out_of_range, out_of_range_i)
               + field_off("member_count", want.member_count, member_count_i);
          if (miss != 0) begin
            fails++;
            $display("%0t   (beat mode %0d value %0d)", $time, want.mode, want.value);
          end
        end
      end
      // any register write empties the set
      if (cfg_we_i) begin
        if (cfg_index_i == CfgLowBound) base_value = cfg_data_i;
        else span_reg = cfg_data_i[SpanW-1:0];
        held_bits = '0;
        tally     = 0;
      end
      if (in_valid_i && !in_stall_i) awaited_answers.push_back(predict_set_op(mode_i, value_i));
    end
    pending_o    <= awaited_answers.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

>>> tb/bitmap_integer_set_tb.sv
module bitmap_integer_set_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bis_pkg::*;

  localparam logic [ModeW-1:0]         ModeUnusedFirst = ModeComplement + 1'b1;
  localparam logic [ModeW-1:0]         ModeUnusedLast  = '1;
  localparam logic signed [ValueW-1:0] ValueMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] ValueMin = {1'b1, {(ValueW-1){1'b0}}};

  typedef enum {StallNone, StallLight, StallHeavy, StallPeriodic} stall_style_e;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic [CfgDataW-1:0]      cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic [ModeW-1:0]         mode      = '0;
  logic signed [ValueW-1:0] value     = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic                     success;
  logic                     out_of_range;
  logic [CountW-1:0]        member_count;
  int                       fail_count;
  int                       pending;
  int                       checked;

  int           beats_by_mode[2**ModeW];
  int           total_beats = 0;
  int           reg_writes  = 0;
  int           burst_left  = 0;
  stall_style_e stall_style = StallNone;
  int           stall_hold  = 0;

  always #6 clk = ~clk;

  bitmap_integer_set i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .success_o      (success),
    .out_of_range_o (out_of_range),
    .member_count_o (member_count)
  );

  bitmap_set_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .value_i        (value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .success_i      (success),
    .out_of_range_i (out_of_range),
    .member_count_i (member_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // receiver back-pressure, in a stall style that is picked anew at random
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_style = stall_style_e'($urandom_range(StallNone, StallPeriodic));
      stall_hold  = $urandom_range(20, 150);
    end
    stall_hold--;
    case (stall_style)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 9) < 6);
      default:    out_stall <= (stall_hold % 5) < 2;
    endcase
  end

  task automatic send_beat(logic [ModeW-1:0] m, logic signed [ValueW-1:0] v);
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    do @(posedge clk); while (in_stall);
    beats_by_mode[m]++;
    total_beats++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      // some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_bounds(logic signed [LowBoundW-1:0] lo, logic [SpanW-1:0] sp);
    logic [CfgDataW-1:0] span_word;
    // upper bits of the span write are junk the block must drop
    span_word            = $urandom;
    span_word[SpanW-1:0] = sp;
    if ($urandom_range(0, 1)) begin
      write_reg(CfgLowBound, lo);
      write_reg(CfgRangeSpan, span_word);
    end else begin
      write_reg(CfgRangeSpan, span_word);
      write_reg(CfgLowBound, lo);
    end
  endtask

  task automatic run_phase(logic signed [LowBoundW-1:0] lo, logic [SpanW-1:0] sp, int n);
    int                       pause_at;
    int unsigned              pick;
    int unsigned              off;
    logic [ModeW-1:0]         m;
    logic signed [ValueW-1:0] v;
    pause_at = $urandom_range(n / 4, 3 * n / 4);
    wait_drained();
    set_bounds(lo, sp);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 30)      m = ModeFind;
      else if (pick < 63) m = ModeAdd;
      else if (pick < 90) m = ModeRemove;
      else if (pick < 94) m = ModeClear;
      else if (pick < 97) m = ModeComplement;
      else                m = ModeW'($urandom_range(ModeUnusedFirst, ModeUnusedLast));
      // mostly in range, half of those in a narrow window so values repeat
      off  = $urandom_range(0, 1) ? $urandom_range(0, sp)
                                  : $urandom_range(0, (sp < 15) ? sp : 15);
      pick = $urandom_range(0, 9);
      if (pick < 7)       v = lo + off;
      else if (pick == 7) v = lo - 1 - $urandom_range(0, 3);
      else if (pick == 8) v = lo + sp + 1 + $urandom_range(0, 3);
      else                v = $urandom;
      send_beat(m, v);
    end
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default bounds 0..1023
    send_beat(ModeFind, 0);
    send_beat(ModeAdd, 0);
    send_beat(ModeAdd, 0);
    send_beat(ModeAdd, 1023);
    send_beat(ModeFind, 1023);
    send_beat(ModeAdd, 1024);
    send_beat(ModeAdd, -1);
    send_beat(ModeFind, ValueMax);
    send_beat(ModeRemove, 5);
    send_beat(ModeRemove, 0);
    send_beat(ModeComplement, ValueMax);
    send_beat(ModeFind, 0);
    send_beat(ModeRemove, 1023);
    send_beat(ModeClear, $urandom);
    send_beat(ModeUnusedFirst, $urandom);
    send_beat(ModeUnusedFirst + 1'b1, $urandom);
    send_beat(ModeUnusedLast, $urandom);
    send_beat(ModeComplement, ValueMin);

    // top of the integer range
    wait_drained();
    set_bounds(ValueMax - 1023, '1);
    send_beat(ModeAdd, ValueMax);
    send_beat(ModeFind, ValueMin);

    // single member at the bottom
    wait_drained();
    set_bounds(ValueMin, '0);
    send_beat(ModeAdd, ValueMin);
    send_beat(ModeFind, ValueMax);
    send_beat(ModeComplement, $urandom);
    send_beat(ModeComplement, $urandom);
    send_beat(ModeAdd, ValueMin + 1);

    run_phase(0, '1, 80);
    run_phase(ValueMin, '0, 80);
    run_phase(ValueMax - 1023, '1, 80);
    run_phase(ValueMax, '0, 80);
    run_phase(-100, SpanW'(63), 80);
    run_phase($urandom, SpanW'($urandom_range(0, 40)), 80);
    run_phase($urandom, '1, 80);
    run_phase(ValueMin, '1, 80);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d beats: find %0d, add %0d, remove %0d, clear %0d, complement %0d",
             total_beats, beats_by_mode[ModeFind], beats_by_mode[ModeAdd],
             beats_by_mode[ModeRemove], beats_by_mode[ModeClear],
             beats_by_mode[ModeComplement]);
    $display("plus unused modes, %0d register writes over 10 bound settings, %0d results checked",
             reg_writes, checked);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
